// ===== rtl/lbba_pkg.sv =====
// Package for the LRU block buffer allocator.
// Holds sizes, status and operation codes, the link write struct and link reset values.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package lbba_pkg;

    localparam int NUM_BUFFERS       = 16;
    localparam int BLOCK_NUMBER_BITS = 24;
    localparam int IDX_BITS          = $clog2(NUM_BUFFERS);
    localparam int COUNT_BITS        = $clog2(NUM_BUFFERS + 1);
    localparam int INDEX_FIELD_BITS  = 4;
    localparam int STATUS_BITS       = 2;

    localparam logic OP_GET     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef logic [IDX_BITS-1:0]          buf_idx_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [BLOCK_NUMBER_BITS-1:0] block_t;
    typedef logic [INDEX_FIELD_BITS-1:0]  index_field_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_FREE      = 2'd1,
        STATUS_BUSY         = 2'd2,
        STATUS_IDLE_RELEASE = 2'd3
    } status_t;

    typedef struct packed {
        logic     en;
        buf_idx_t addr;
        buf_idx_t data;
    } link_wr_t;

    function automatic buf_idx_t next_init(buf_idx_t i);
        return IDX_BITS'((int'(i) + 1) % NUM_BUFFERS);
    endfunction

    function automatic buf_idx_t prev_init(buf_idx_t i);
        return IDX_BITS'((int'(i) + NUM_BUFFERS - 1) % NUM_BUFFERS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lbba_req_if.sv =====
// Request channel of the LRU block buffer allocator: valid, ready and the request fields.
// Depends on lbba_pkg for the field widths.
`default_nettype none

interface lbba_req_if;

    logic                  valid;
    logic                  ready;
    logic                  op;
    lbba_pkg::block_t      block_number;
    lbba_pkg::index_field_t release_index;

    modport source (output valid, output op, output block_number, output release_index,
                    input ready);
    modport sink (input valid, input op, input block_number, input release_index,
                  output ready);

endinterface

`default_nettype wire

// ===== rtl/lbba_rsp_if.sv =====
// Response channel of the LRU block buffer allocator: valid, ready and the result fields.
// Depends on lbba_pkg for the field widths.
`default_nettype none

interface lbba_rsp_if;

    logic                   valid;
    logic                   ready;
    lbba_pkg::index_field_t buffer_index;
    logic                   was_hit;
    logic [lbba_pkg::STATUS_BITS-1:0] status;

    modport source (output valid, output buffer_index, output was_hit, output status,
                    input ready);
    modport sink (input valid, input buffer_index, input was_hit, input status,
                  output ready);

endinterface

`default_nettype wire

// ===== rtl/lbba_link_ram.sv =====
// Free list link store: next and prev memories with one read and one write port each.
// Entries never written read back as their reset links. Depends on lbba_pkg.
`default_nettype none

module lbba_link_ram (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire lbba_pkg::buf_idx_t rd_addr,
    input  wire lbba_pkg::link_wr_t next_wr,
    input  wire lbba_pkg::link_wr_t prev_wr,
    output lbba_pkg::buf_idx_t      next_q,
    output lbba_pkg::buf_idx_t      prev_q
);

    lbba_pkg::buf_idx_t next_mem [lbba_pkg::NUM_BUFFERS];
    lbba_pkg::buf_idx_t prev_mem [lbba_pkg::NUM_BUFFERS];

    logic [lbba_pkg::NUM_BUFFERS-1:0] next_vld_reg;
    logic [lbba_pkg::NUM_BUFFERS-1:0] prev_vld_reg;
    lbba_pkg::buf_idx_t               next_rd_reg;
    lbba_pkg::buf_idx_t               prev_rd_reg;
    lbba_pkg::buf_idx_t               rd_addr_reg;
    logic                             next_rd_vld_reg;
    logic                             prev_rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (next_wr.en)
        begin
            next_mem[next_wr.addr] <= next_wr.data;
        end
        if (prev_wr.en)
        begin
            prev_mem[prev_wr.addr] <= prev_wr.data;
        end
        if (rd_en)
        begin
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_vld_reg    <= '0;
            prev_vld_reg    <= '0;
            next_rd_vld_reg <= 1'b0;
            prev_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (next_wr.en)
            begin
                next_vld_reg[next_wr.addr] <= 1'b1;
            end
            if (prev_wr.en)
            begin
                prev_vld_reg[prev_wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                next_rd_vld_reg <= next_vld_reg[rd_addr];
                prev_rd_vld_reg <= prev_vld_reg[rd_addr];
            end
        end
    end

    assign next_q = next_rd_vld_reg ? next_rd_reg : lbba_pkg::next_init(rd_addr_reg);
    assign prev_q = prev_rd_vld_reg ? prev_rd_reg : lbba_pkg::prev_init(rd_addr_reg);

endmodule

`default_nettype wire

// ===== rtl/lru_block_buffer_allocator.sv =====
// LRU block buffer allocator: tag lookup in flip-flops, free list links in lbba_link_ram.
// A request is taken in S_IDLE and its link entries are read into registers; S_UPDATE then
// writes the links and the response, and no new request is taken until it returns to S_IDLE.
// A waiting response does not block the next request; it only holds the update cycle.
// Reset: all buffers free in index order, no tag valid, no buffer busy; no clearing pass.
// Depends on lbba_pkg, lbba_req_if, lbba_rsp_if and lbba_link_ram.
`default_nettype none

module lru_block_buffer_allocator (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbba_req_if.sink   req,
    lbba_rsp_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_UNLINK,
        ACT_APPEND
    } act_t;

    state_t state_reg, state_next;

    lbba_pkg::block_t                 tag_reg [lbba_pkg::NUM_BUFFERS];
    logic [lbba_pkg::NUM_BUFFERS-1:0] valid_reg, valid_next;
    logic [lbba_pkg::NUM_BUFFERS-1:0] busy_reg, busy_next;
    lbba_pkg::buf_idx_t               head_reg, head_next;
    lbba_pkg::buf_idx_t               tail_reg, tail_next;
    lbba_pkg::count_t                 count_reg, count_next;

    lbba_pkg::buf_idx_t     idx_reg;
    lbba_pkg::index_field_t item_index_reg;
    logic                   item_hit_reg;
    lbba_pkg::status_t      item_status_reg;
    act_t                   act_reg;

    logic                   out_valid_reg, out_valid_next;
    lbba_pkg::index_field_t out_index_reg, out_index_next;
    logic                   out_hit_reg, out_hit_next;
    lbba_pkg::status_t      out_status_reg, out_status_next;

    logic                   accept;
    logic                   out_free;
    logic                   found;
    lbba_pkg::buf_idx_t     match_idx;
    logic                   rel_in_range;
    lbba_pkg::buf_idx_t     rel_idx;
    lbba_pkg::buf_idx_t     dec_idx;
    lbba_pkg::index_field_t dec_index;
    logic                   dec_hit;
    lbba_pkg::status_t      dec_status;
    act_t                   dec_act;
    logic                   dec_retag;
    logic                   dec_busy_set;
    logic                   dec_busy_clr;

    lbba_pkg::link_wr_t next_wr;
    lbba_pkg::link_wr_t prev_wr;
    lbba_pkg::buf_idx_t link_next;
    lbba_pkg::buf_idx_t link_prev;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int i = lbba_pkg::NUM_BUFFERS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == req.block_number))
            begin
                found     = 1'b1;
                match_idx = lbba_pkg::IDX_BITS'(i);
            end
        end
    end

    assign rel_in_range = (int'(req.release_index) < lbba_pkg::NUM_BUFFERS);
    assign rel_idx      = lbba_pkg::IDX_BITS'(req.release_index);

    always_comb
    begin
        dec_idx      = '0;
        dec_hit      = 1'b0;
        dec_status   = lbba_pkg::STATUS_OK;
        dec_act      = ACT_NONE;
        dec_retag    = 1'b0;
        dec_busy_set = 1'b0;
        dec_busy_clr = 1'b0;
        if (req.op == lbba_pkg::OP_GET)
        begin
            if (found)
            begin
                dec_idx = match_idx;
                dec_hit = 1'b1;
                if (busy_reg[match_idx])
                begin
                    dec_status = lbba_pkg::STATUS_BUSY;
                end
                else
                begin
                    dec_act      = ACT_UNLINK;
                    dec_busy_set = 1'b1;
                end
            end
            else if (count_reg == '0)
            begin
                dec_status = lbba_pkg::STATUS_NO_FREE;
            end
            else
            begin
                dec_idx      = head_reg;
                dec_act      = ACT_UNLINK;
                dec_retag    = 1'b1;
                dec_busy_set = 1'b1;
            end
        end
        else
        begin
            dec_idx = rel_idx;
            if (rel_in_range && busy_reg[rel_idx])
            begin
                dec_act      = ACT_APPEND;
                dec_busy_clr = 1'b1;
            end
            else
            begin
                dec_status = lbba_pkg::STATUS_IDLE_RELEASE;
            end
        end
        dec_index = (req.op == lbba_pkg::OP_GET) ?
                    lbba_pkg::INDEX_FIELD_BITS'(dec_idx) : req.release_index;
    end

    lbba_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (dec_idx),
        .next_wr (next_wr),
        .prev_wr (prev_wr),
        .next_q  (link_next),
        .prev_q  (link_prev)
    );

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        busy_next       = busy_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_index_next  = out_index_reg;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        next_wr         = '0;
        prev_wr         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                    if (dec_retag)
                    begin
                        valid_next[dec_idx] = 1'b1;
                    end
                    if (dec_busy_set)
                    begin
                        busy_next[dec_idx] = 1'b1;
                    end
                    if (dec_busy_clr)
                    begin
                        busy_next[dec_idx] = 1'b0;
                    end
                end
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_index_next  = item_index_reg;
                    out_hit_next    = item_hit_reg;
                    out_status_next = item_status_reg;
                    case (act_reg)
                        ACT_UNLINK:
                        begin
                            if (idx_reg == head_reg)
                            begin
                                head_next = link_next;
                            end
                            else
                            begin
                                next_wr = '{en: 1'b1, addr: link_prev, data: link_next};
                            end
                            if (idx_reg == tail_reg)
                            begin
                                tail_next = link_prev;
                            end
                            else
                            begin
                                prev_wr = '{en: 1'b1, addr: link_next, data: link_prev};
                            end
                            count_next = count_reg - lbba_pkg::COUNT_BITS'(1);
                        end
                        ACT_APPEND:
                        begin
                            if (count_reg == '0)
                            begin
                                head_next = idx_reg;
                            end
                            else
                            begin
                                next_wr = '{en: 1'b1, addr: tail_reg, data: idx_reg};
                                prev_wr = '{en: 1'b1, addr: idx_reg, data: tail_reg};
                            end
                            tail_next  = idx_reg;
                            count_next = count_reg + lbba_pkg::COUNT_BITS'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            busy_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= lbba_pkg::IDX_BITS'(lbba_pkg::NUM_BUFFERS - 1);
            count_reg     <= lbba_pkg::COUNT_BITS'(lbba_pkg::NUM_BUFFERS);
            act_reg       <= ACT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            busy_reg      <= busy_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                act_reg <= dec_act;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
        if (accept)
        begin
            idx_reg         <= dec_idx;
            item_index_reg  <= dec_index;
            item_hit_reg    <= dec_hit;
            item_status_reg <= dec_status;
            if (dec_retag)
            begin
                tag_reg[dec_idx] <= req.block_number;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.buffer_index = out_index_reg;
    assign rsp.was_hit      = out_hit_reg;
    assign rsp.status       = out_status_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= lbba_pkg::NUM_BUFFERS)
        else $error("free count exceeds the number of buffers");

    a_busy_free_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            (int'($countones(busy_reg)) + int'(count_reg) == lbba_pkg::NUM_BUFFERS))
        else $error("busy buffers and free list count disagree");

    a_unlink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && act_reg == ACT_UNLINK) |-> (count_reg != '0))
        else $error("unlink requested on an empty free list");

    a_busy_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == lbba_pkg::STATUS_BUSY) |-> rsp.was_hit)
        else $error("busy status reported without a hit");
`endif

endmodule

`default_nettype wire
